### src/wsm_pkg.sv
// Shared types and constants for the wildcard string matcher.
`timescale 1ns / 1ps

package wsm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int NUM_POS     = MAX_PATTERN + 1;

   localparam logic [7:0] WILD_RESET = 8'd42;
   localparam logic [7:0] WILD_OFF   = 8'd0;

   localparam logic KIND_PATTERN = 1'b0;
   localparam logic KIND_TEXT    = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_value;
      logic       first;
      logic       last;
      logic       no_char;
   } req_beat_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } rsp_beat_type;

   // Broadcast to every position cell.
   typedef struct packed {
      logic [7:0] ch;
      logic [7:0] wild_char;
      logic       pattern_step;
      logic       text_step;
      logic       restart;
      logic       use_char;
      logic       last;
   } cell_bcast_type;

   // Per-cell view of where the pattern ends.
   typedef struct packed {
      logic origin;
      logic in_use;
      logic at_end;
      logic load;
   } cell_pos_type;

endpackage

### src/wsm_cell.sv
// One pattern position: stored character, active flag, and chain links.
`timescale 1ns / 1ps

module wsm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  wsm_pkg::cell_bcast_type bc,
   input  wsm_pkg::cell_pos_type   pos,
   input  logic                   skip_in,
   input  logic                   adv_in,
   input  logic                   tail_in,
   output logic                   skip_out,
   output logic                   adv_out,
   output logic                   tail_out,
   output logic                   hit
);

   logic [7:0] char_ff;
   logic       active_ff;
   logic       active_in;
   logic       active_eff;
   logic       closed;
   logic       wild;
   logic       nxt;
   logic       post;

   always_comb begin
      active_eff = bc.restart ? pos.origin : active_ff;
      closed     = active_eff | skip_in;
      wild       = pos.in_use && (bc.wild_char != wsm_pkg::WILD_OFF)
                   && (char_ff == bc.wild_char);
      skip_out   = closed & wild;
      adv_out    = closed & pos.in_use & ~wild & (char_ff == bc.ch);
      nxt        = skip_out | adv_in;
      post       = bc.use_char ? nxt : active_eff;
      // all positions from here to the pattern end are wild
      tail_out   = pos.at_end | (wild & tail_in);
      hit        = post & tail_out;
   end

   always_comb begin
      active_in = active_ff;
      if (bc.pattern_step) begin
         active_in = pos.origin;
      end else if (bc.text_step) begin
         if (bc.last) begin
            active_in = pos.origin;
         end else if (bc.use_char) begin
            active_in = nxt;
         end else begin
            active_in = active_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= pos.origin;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pos.load) begin
         char_ff <= bc.ch;
      end
   end

endmodule

### src/wildcard_string_match_core.sv
// Top level of the wildcard string matcher: pattern loader, cell chain, result buffer.
`timescale 1ns / 1ps

// Takes one beat per clock, pattern or text, while req_stall is low, with no gaps needed
// between them. The pattern (up to 32 characters) is written into a row of 33 position
// cells; each text character advances all positions at once, and the text may be of any
// length. The result beat of a text beat marked last is registered into the output register,
// or into the skid slot while the output waits. The clock period is set by the wildcard-skip
// ripple through the 33 cells followed by the match reduction. A two-deep result buffer keeps
// input flowing while a result waits; req_stall rises only when both result slots are full.
module wildcard_string_match_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  wsm_pkg::req_beat_type req_beat,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output wsm_pkg::rsp_beat_type rsp_beat,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data
);

   localparam int NP = wsm_pkg::NUM_POS;
   localparam int LW = wsm_pkg::LEN_W;

   logic [7:0]    wild_ff;
   logic [LW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   wsm_pkg::rsp_beat_type rsp_beat_ff, rsp_beat_in;
   logic                  skid_valid_ff, skid_valid_in;
   wsm_pkg::rsp_beat_type skid_beat_ff, skid_beat_in;

   logic          accept;
   logic          is_text;
   logic          produce;
   logic          take;
   logic          char_wr;
   logic [LW-1:0] widx;
   logic          room;
   logic          any_hit;
   wsm_pkg::rsp_beat_type new_beat;
   wsm_pkg::cell_bcast_type bc;

   wsm_pkg::cell_pos_type pos [NP];
   logic [NP-1:0] skip_out;
   logic [NP-1:0] adv_out;
   logic [NP-1:0] tail_out;
   logic [NP-1:0] skip_in;
   logic [NP-1:0] adv_in;
   logic [NP-1:0] tail_in;
   logic [NP-1:0] hit;

   assign accept  = req_valid & ~req_stall;
   assign is_text = (req_beat.kind == wsm_pkg::KIND_TEXT);
   assign produce = accept & is_text & req_beat.last;
   assign take    = rsp_valid_ff & ~rsp_stall;

   // pattern loading
   always_comb begin
      char_wr = accept & ~is_text & ~req_beat.no_char;
      widx    = req_beat.first ? '0 : len_ff;
      room    = (widx < LW'(wsm_pkg::MAX_PATTERN));
      len_in  = len_ff;
      ovf_in  = ovf_ff;
      if (accept && !is_text) begin
         len_in = widx + LW'(char_wr & room);
         ovf_in = (req_beat.first ? 1'b0 : ovf_ff) | (char_wr & ~room);
      end
   end

   always_comb begin
      bc.ch           = req_beat.char_value;
      bc.wild_char    = wild_ff;
      bc.pattern_step = accept & ~is_text;
      bc.text_step    = accept & is_text;
      bc.restart      = req_beat.first;
      bc.use_char     = ~req_beat.no_char;
      bc.last         = req_beat.last;
   end

   for (genvar g = 0; g < NP; g++) begin : g_pos
      always_comb begin
         pos[g].origin = (g == 0);
         pos[g].in_use = (len_ff > LW'(g));
         pos[g].at_end = (len_ff == LW'(g));
         pos[g].load   = char_wr & room & (widx == LW'(g));
      end

      if (g == 0) begin : g_head
         assign skip_in[g] = 1'b0;
         assign adv_in[g]  = 1'b0;
      end else begin : g_link
         assign skip_in[g] = skip_out[g-1];
         assign adv_in[g]  = adv_out[g-1];
      end

      if (g == NP - 1) begin : g_tail
         assign tail_in[g] = 1'b0;
      end else begin : g_back
         assign tail_in[g] = tail_out[g+1];
      end

      wsm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .bc       (bc),
         .pos      (pos[g]),
         .skip_in  (skip_in[g]),
         .adv_in   (adv_in[g]),
         .tail_in  (tail_in[g]),
         .skip_out (skip_out[g]),
         .adv_out  (adv_out[g]),
         .tail_out (tail_out[g]),
         .hit      (hit[g])
      );
   end

   assign any_hit = |hit;

   always_comb begin
      new_beat.matched          = any_hit & ~ovf_ff;
      new_beat.pattern_overflow = ovf_ff;
   end

   // result buffer: output register plus one skid slot
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_beat_in   = rsp_beat_ff;
      skid_valid_in = skid_valid_ff;
      skid_beat_in  = skid_beat_ff;
      if (!rsp_valid_ff || take) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_beat_in   = skid_beat_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = produce;
            rsp_beat_in  = new_beat;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_beat_in  = new_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wild_ff       <= wsm_pkg::WILD_RESET;
         len_ff        <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            wild_ff <= csr_wr_data;
         end
         len_ff        <= len_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff  <= rsp_beat_in;
      skid_beat_ff <= skid_beat_in;
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid slot holds a beat while output register is empty");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(wsm_pkg::MAX_PATTERN))
      else $error("pattern length beyond store depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (len_ff == LW'(wsm_pkg::MAX_PATTERN)))
      else $error("overflow flagged with room left in store");

   a_no_match_on_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_beat_ff.matched && rsp_beat_ff.pattern_overflow))
      else $error("match reported for an overflowed pattern");

   a_produce_lands: assert property (@(posedge clock) disable iff (reset)
      produce |=> rsp_valid_ff)
      else $error("result beat lost");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the wildcard string matcher core.
`timescale 1ns / 1ps

module tb_top;

   class glob_match_predictor;
      logic [7:0] wild;
      logic [7:0] pat [wsm_pkg::MAX_PATTERN];
      int unsigned pat_len;
      logic [wsm_pkg::NUM_POS-1:0] live;
      logic ovf;
      wsm_pkg::rsp_beat_type verdicts_due[$];
      int errors;
      int verdicts_seen;
      int hits;
      int ovf_verdicts;

      function new();
         wild = wsm_pkg::WILD_RESET;
         pat_len = 0;
         live = wsm_pkg::NUM_POS'(1);
         ovf = 1'b0;
         errors = 0;
         verdicts_seen = 0;
         hits = 0;
         ovf_verdicts = 0;
         foreach (pat[i]) pat[i] = 8'd0;
      endfunction

      function bit is_wild(logic [7:0] c);
         return wild != wsm_pkg::WILD_OFF && c == wild;
      endfunction

      // A wildcard at a live position also makes the next position live.
      function logic [wsm_pkg::NUM_POS-1:0] skip_wilds(logic [wsm_pkg::NUM_POS-1:0] s);
         for (int i = 0; i < pat_len; i++)
            if (s[i] && is_wild(pat[i])) s[i+1] = 1'b1;
         return s;
      endfunction

      function void take_req_beat(wsm_pkg::req_beat_type b);
         logic [wsm_pkg::NUM_POS-1:0] s;
         logic [wsm_pkg::NUM_POS-1:0] nxt;
         wsm_pkg::rsp_beat_type v;
         if (b.kind == wsm_pkg::KIND_PATTERN) begin
            if (b.first) begin
               pat_len = 0;
               ovf = 1'b0;
            end
            if (!b.no_char) begin
               if (pat_len < wsm_pkg::MAX_PATTERN) begin
                  pat[pat_len] = b.char_value;
                  pat_len++;
               end else begin
                  ovf = 1'b1;
               end
            end
            live = wsm_pkg::NUM_POS'(1);
            return;
         end
         if (b.first) live = wsm_pkg::NUM_POS'(1);
         if (!b.no_char) begin
            s = skip_wilds(live);
            nxt = '0;
            for (int i = 0; i < pat_len; i++) begin
               if (s[i]) begin
                  if (is_wild(pat[i])) nxt[i] = 1'b1;
                  else if (pat[i] == b.char_value) nxt[i+1] = 1'b1;
               end
            end
            live = nxt;
         end
         if (!b.last) return;
         s = skip_wilds(live);
         v.matched = s[pat_len] && !ovf;
         v.pattern_overflow = ovf;
         verdicts_due = {verdicts_due, v};
         live = wsm_pkg::NUM_POS'(1);
      endfunction

      function void check_rsp_beat(wsm_pkg::rsp_beat_type got);
         wsm_pkg::rsp_beat_type exp;
         verdicts_seen++;
         if (verdicts_due.size() == 0) begin
            $error("unexpected result beat: matched=%0b pattern_overflow=%0b",
                   got.matched, got.pattern_overflow);
            errors++;
            return;
         end
         exp = verdicts_due.pop_front();
         if (exp.matched) hits++;
         if (exp.pattern_overflow) ovf_verdicts++;
         if (got.matched !== exp.matched) begin
            $error("matched: expected %0b, got %0b", exp.matched, got.matched);
            errors++;
         end
         if (got.pattern_overflow !== exp.pattern_overflow) begin
            $error("pattern_overflow: expected %0b, got %0b",
                   exp.pattern_overflow, got.pattern_overflow);
            errors++;
         end
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   wsm_pkg::req_beat_type req_beat;
   logic rsp_valid;
   logic rsp_stall;
   wsm_pkg::rsp_beat_type rsp_beat;
   logic csr_wr_en;
   logic [7:0] csr_wr_data;

   glob_match_predictor sb;
   bit calm;
   int beats_sent;
   int wild_writes;

   wildcard_string_match_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_beat    (req_beat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_beat    (rsp_beat),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // result side: random stall, checked at the rising edge
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= !calm && ($urandom_range(99) < 26);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_rsp_beat(rsp_beat);
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic push_beat(input logic k, input logic [7:0] c, input logic f,
                            input logic l, input logic n);
      wsm_pkg::req_beat_type b;
      b.kind = k;
      b.char_value = c;
      b.first = f;
      b.last = l;
      b.no_char = n;
      while (!calm && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_beat <= b;
      do @(posedge clock); while (req_stall);
      sb.take_req_beat(b);
      beats_sent++;
      @(negedge clock);
   endtask

   // Drain all results, let the core settle, then write the wildcard code.
   task automatic write_wild(input logic [7:0] w);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= w;
      sb.wild = w;
      wild_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] pick_text_char();
      case ($urandom_range(0, 5))
         0: return "a";
         1: return "b";
         2: return "c";
         3: return 8'h00;
         4: return 8'hFF;
         default: return sb.wild;
      endcase
   endfunction

   function automatic logic [7:0] pick_pat_char();
      if (sb.wild != wsm_pkg::WILD_OFF && $urandom_range(99) < 30) return sb.wild;
      case ($urandom_range(0, 4))
         0: return "a";
         1: return "b";
         2: return "c";
         3: return 8'h00;
         default: return 8'hFF;
      endcase
   endfunction

   task automatic load_pattern(input int len);
      if (len == 0) begin
         push_beat(wsm_pkg::KIND_PATTERN, 8'($urandom), 1'b1,
                   1'($urandom_range(0, 1)), 1'b1);
         return;
      end
      for (int i = 0; i < len; i++)
         push_beat(wsm_pkg::KIND_PATTERN, pick_pat_char(), i == 0,
                   1'($urandom_range(0, 1)), 1'b0);
   endtask

   task automatic send_text(input bit aim_hit);
      logic [7:0] txt[$];
      int n;
      if (aim_hit) begin
         for (int i = 0; i < sb.pat_len; i++) begin
            if (sb.is_wild(sb.pat[i]))
               repeat ($urandom_range(0, 3)) txt = {txt, pick_text_char()};
            else
               txt = {txt, sb.pat[i]};
         end
      end else begin
         repeat ($urandom_range(0, 8)) txt = {txt, pick_text_char()};
      end
      n = txt.size();
      if (n == 0) begin
         push_beat(wsm_pkg::KIND_TEXT, 8'($urandom), 1'b1, 1'b1, 1'b1);
         return;
      end
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(99) < 10)
            push_beat(wsm_pkg::KIND_TEXT, 8'($urandom), 1'b0, 1'b0, 1'b1);
         push_beat(wsm_pkg::KIND_TEXT, txt[i], i == 0 && $urandom_range(99) < 90,
                   i == n - 1, 1'b0);
      end
   endtask

   initial begin
      logic [7:0] wilds [5];
      int start;
      int r;
      sb = new();
      calm = 1'b0;
      beats_sent = 0;
      wild_writes = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_beat = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'd0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset wildcard '*'
      push_beat(wsm_pkg::KIND_PATTERN, "a", 1'b1, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_PATTERN, wsm_pkg::WILD_RESET, 1'b0, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_PATTERN, "c", 1'b0, 1'b1, 1'b0);
      push_beat(wsm_pkg::KIND_TEXT, "a", 1'b1, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_TEXT, "b", 1'b0, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_TEXT, "c", 1'b0, 1'b1, 1'b0);
      push_beat(wsm_pkg::KIND_TEXT, "a", 1'b1, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_TEXT, 8'h00, 1'b0, 1'b0, 1'b1);
      push_beat(wsm_pkg::KIND_TEXT, "b", 1'b0, 1'b1, 1'b0);
      push_beat(wsm_pkg::KIND_TEXT, "b", 1'b1, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_TEXT, "a", 1'b1, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_TEXT, "c", 1'b0, 1'b1, 1'b0);
      // empty pattern
      push_beat(wsm_pkg::KIND_PATTERN, 8'hFF, 1'b1, 1'b0, 1'b1);
      push_beat(wsm_pkg::KIND_TEXT, 8'hFF, 1'b1, 1'b1, 1'b1);
      push_beat(wsm_pkg::KIND_TEXT, "a", 1'b1, 1'b1, 1'b0);
      // all-wild pattern
      push_beat(wsm_pkg::KIND_PATTERN, wsm_pkg::WILD_RESET, 1'b1, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_PATTERN, wsm_pkg::WILD_RESET, 1'b0, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_TEXT, 8'h00, 1'b1, 1'b1, 1'b1);
      push_beat(wsm_pkg::KIND_TEXT, 8'hFF, 1'b1, 1'b1, 1'b0);
      // extreme codes
      push_beat(wsm_pkg::KIND_PATTERN, 8'h00, 1'b1, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_PATTERN, 8'hFF, 1'b0, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_TEXT, 8'h00, 1'b1, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_TEXT, 8'hFF, 1'b0, 1'b1, 1'b0);
      // wildcard disabled: '*' and code zero are literal
      write_wild(wsm_pkg::WILD_OFF);
      push_beat(wsm_pkg::KIND_PATTERN, wsm_pkg::WILD_RESET, 1'b1, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_PATTERN, 8'h00, 1'b0, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_TEXT, wsm_pkg::WILD_RESET, 1'b1, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_TEXT, 8'h00, 1'b0, 1'b1, 1'b0);
      push_beat(wsm_pkg::KIND_TEXT, "x", 1'b1, 1'b0, 1'b0);
      push_beat(wsm_pkg::KIND_TEXT, 8'h00, 1'b0, 1'b1, 1'b0);

      wilds[0] = wsm_pkg::WILD_RESET;
      wilds[1] = wsm_pkg::WILD_OFF;
      wilds[2] = 8'hFF;
      wilds[3] = 8'($urandom_range(1, 254));
      wilds[4] = "a";
      for (int ph = 0; ph < 5; ph++) begin
         write_wild(wilds[ph]);
         calm = (ph == 2);
         start = beats_sent;
         if (ph == 0) begin
            load_pattern(wsm_pkg::MAX_PATTERN + 1);
            send_text(1'b1);
         end else if (ph == 1) begin
            load_pattern(wsm_pkg::MAX_PATTERN);
            send_text(1'b1);
         end
         while (beats_sent - start < 160) begin
            r = $urandom_range(99);
            if (r < 12)
               push_beat(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (r < 27)
               load_pattern($urandom_range(99) < 8 ? $urandom_range(30, 36)
                                                   : $urandom_range(0, 6));
            else
               send_text($urandom_range(99) < 60);
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      for (int g = 0; g < 20000 && sb.pending() != 0; g++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected results never arrived", sb.pending());
         sb.errors++;
      end
      $display("Run: %0d beats in, %0d results checked (%0d matches, %0d overflowed)",
               beats_sent, sb.verdicts_seen, sb.hits, sb.ovf_verdicts);
      $display("Wildcard register written %0d times, codes 0, 42, 255 and others", wild_writes);
      if (sb.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
